@@ sv/rrts_pkg.sv @@
package rrts_pkg;

    localparam int TASK_SLOTS_DEF      = 64;
    localparam int PRIORITY_LEVELS_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;
    localparam int ID_OUT_W = 6;
    localparam int REAP_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD         = 3'd0,
        CMD_SCHEDULE    = 3'd1,
        CMD_EXIT        = 3'd2,
        CMD_REAP        = 3'd3,
        CMD_TICK        = 3'd4,
        CMD_READ        = 3'd5,
        CMD_PREEMPT_ON  = 3'd6,
        CMD_PREEMPT_OFF = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_NO_SWITCH = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_READY   = 2'd1,
        SLOT_RUNNING = 2'd2,
        SLOT_TERM    = 2'd3
    } slot_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_ADD_COMMIT,
        OP_REAP_FREE,
        OP_EXIT_MARK,
        OP_SCHED_RD,
        OP_SCHED_POP,
        OP_SCHED_REQ,
        OP_PRIO_RD,
        OP_RESP
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    cap;
        logic    preempt_on;
        logic    preempt_off;
        status_t status;
        logic    add_resp;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic slot_term;
        logic scan_last;
        logic queue_empty;
        logic preempt;
    } dp_stat_t;

endpackage

@@ sv/round_robin_task_scheduler_core.sv @@
// Round-robin task-slot scheduler. A command beat is taken when start is high and busy is low;
// busy stays high until the result, and the result is shown for exactly one cycle with done
// high. The receiver cannot stall it, so capture it on that cycle. busy drops in the done
// cycle, so the next command can be taken there. Schedule, exit and an enabled timer tick
// with a non-empty queue pass S_SCHED_RD, S_SCHED_POP and S_SCHED_REQ before S_PRIO_RD and
// S_RESP; those commands with an empty queue, a disabled tick, read current and the preempt
// commands go from S_DECODE straight to S_PRIO_RD. Add scans from slot 1 up to the first free
// slot and reap sweeps slots 1 to TASK_SLOTS-1; the slot-state table has one read port with
// registered data, so each slot is read in S_SCAN_RD and tested in S_SCAN_CHK.
module round_robin_task_scheduler_core
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    command,
    input  logic [PRIO_W-1:0]   new_priority,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_OUT_W-1:0] task_id,
    output logic [ID_OUT_W-1:0] previous_id,
    output logic                switched,
    output logic [REAP_W-1:0]   reaped_count,
    output logic [PRIO_W-1:0]   task_priority
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    rrts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    rrts_datapath #(
        .TASK_SLOTS      (TASK_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .new_priority  (new_priority),
        .done          (done),
        .status        (status),
        .task_id       (task_id),
        .previous_id   (previous_id),
        .switched      (switched),
        .reaped_count  (reaped_count),
        .task_priority (task_priority)
    );

endmodule

@@ sv/rrts_datapath.sv @@
module rrts_datapath
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             dp_cmd,
    output dp_stat_t            dp_stat,
    input  logic [PRIO_W-1:0]   new_priority,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_OUT_W-1:0] task_id,
    output logic [ID_OUT_W-1:0] previous_id,
    output logic                switched,
    output logic [REAP_W-1:0]   reaped_count,
    output logic [PRIO_W-1:0]   task_priority
);

    localparam int ID_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam logic [ID_W-1:0]   LAST_ID  = ID_W'(TASK_SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(TASK_SLOTS);
    localparam logic [PRIO_W-1:0] IDLE_PRIO = PRIO_W'((PRIORITY_LEVELS - 1) & 15);

    function automatic logic [ID_W-1:0] id_inc(input logic [ID_W-1:0] x);
        if (x == LAST_ID)
        begin
            return '0;
        end
        return x + ID_W'(1);
    endfunction

    // slot tables and ready ring
    slot_state_t       state_mem [TASK_SLOTS];
    logic [PRIO_W-1:0] prio_mem  [TASK_SLOTS];
    logic [ID_W-1:0]   fifo_mem  [TASK_SLOTS];

    // entries not yet written read as their reset value
    logic [TASK_SLOTS-1:0] state_vld_reg, state_vld_next;
    logic [TASK_SLOTS-1:0] prio_vld_reg,  prio_vld_next;

    slot_state_t       state_rd_reg;
    logic [PRIO_W-1:0] prio_rd_reg;
    logic [ID_W-1:0]   fifo_rd_reg;

    logic [ID_W-1:0]   head_reg,    head_next;
    logic [ID_W-1:0]   tail_reg,    tail_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [ID_W-1:0]   current_reg, current_next;
    logic              preempt_reg, preempt_next;
    logic [ID_W-1:0]   scan_reg,    scan_next;
    logic [ID_W-1:0]   nxt_reg,     nxt_next;
    logic              old_run_reg, old_run_next;
    logic [ID_W-1:0]   prev_reg,    prev_next;
    logic              sw_reg,      sw_next;
    logic [ID_W-1:0]   reap_reg,    reap_next;
    logic [PRIO_W-1:0] nprio_reg,   nprio_next;
    logic              done_reg,    done_next;

    logic [STATUS_W-1:0] status_reg,  status_next;
    logic [ID_OUT_W-1:0] id_reg,      id_next;
    logic [ID_OUT_W-1:0] prev_o_reg,  prev_o_next;
    logic                sw_o_reg,    sw_o_next;
    logic [REAP_W-1:0]   reap_o_reg,  reap_o_next;
    logic [PRIO_W-1:0]   prio_o_reg,  prio_o_next;

    logic              st_wr_en;
    logic [ID_W-1:0]   st_wr_addr;
    slot_state_t       st_wr_data;
    logic              st_rd_en;
    logic [ID_W-1:0]   st_rd_addr;
    logic              pr_wr_en;
    logic [ID_W-1:0]   pr_wr_addr;
    logic [PRIO_W-1:0] pr_wr_data;
    logic              pr_rd_en;
    logic              fifo_rd_en;
    logic              push_en;
    logic              push_ok;
    logic [ID_W-1:0]   push_id;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        current_next   = current_reg;
        preempt_next   = preempt_reg;
        scan_next      = scan_reg;
        nxt_next       = nxt_reg;
        old_run_next   = old_run_reg;
        prev_next      = prev_reg;
        sw_next        = sw_reg;
        reap_next      = reap_reg;
        nprio_next     = nprio_reg;
        done_next      = 1'b0;
        state_vld_next = state_vld_reg;
        prio_vld_next  = prio_vld_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        prev_o_next    = prev_o_reg;
        sw_o_next      = sw_o_reg;
        reap_o_next    = reap_o_reg;
        prio_o_next    = prio_o_reg;

        st_wr_en   = 1'b0;
        st_wr_addr = scan_reg;
        st_wr_data = SLOT_FREE;
        st_rd_en   = 1'b0;
        st_rd_addr = scan_reg;
        pr_wr_en   = 1'b0;
        pr_wr_addr = scan_reg;
        pr_wr_data = '0;
        pr_rd_en   = 1'b0;
        fifo_rd_en = 1'b0;
        push_en    = 1'b0;
        push_id    = scan_reg;

        if (dp_cmd.cap)
        begin
            nprio_next = new_priority;
            prev_next  = current_reg;
            sw_next    = 1'b0;
            reap_next  = '0;
        end
        if (dp_cmd.preempt_on)
        begin
            preempt_next = 1'b1;
        end
        if (dp_cmd.preempt_off)
        begin
            preempt_next = 1'b0;
        end

        case (dp_cmd.op)
            OP_SCAN_INIT:
            begin
                scan_next = ID_W'(1);
            end
            OP_SCAN_RD:
            begin
                st_rd_en = 1'b1;
            end
            OP_SCAN_NEXT:
            begin
                scan_next = scan_reg + ID_W'(1);
            end
            OP_ADD_COMMIT:
            begin
                st_wr_en   = 1'b1;
                st_wr_data = SLOT_READY;
                pr_wr_en   = 1'b1;
                pr_wr_data = nprio_reg;
                push_en    = 1'b1;
            end
            OP_REAP_FREE:
            begin
                st_wr_en  = 1'b1;
                pr_wr_en  = 1'b1;
                reap_next = reap_reg + ID_W'(1);
                scan_next = scan_reg + ID_W'(1);
            end
            OP_EXIT_MARK:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = current_reg;
                st_wr_data = SLOT_TERM;
            end
            OP_SCHED_RD:
            begin
                st_rd_en   = 1'b1;
                st_rd_addr = current_reg;
                fifo_rd_en = 1'b1;
            end
            OP_SCHED_POP:
            begin
                // new task goes running first, so a head equal to current counts as running
                st_wr_en     = 1'b1;
                st_wr_addr   = fifo_rd_reg;
                st_wr_data   = SLOT_RUNNING;
                head_next    = id_inc(head_reg);
                count_next   = count_reg - CNT_W'(1);
                nxt_next     = fifo_rd_reg;
                old_run_next = (fifo_rd_reg == current_reg) || (state_rd_reg == SLOT_RUNNING);
            end
            OP_SCHED_REQ:
            begin
                if (old_run_reg)
                begin
                    st_wr_en   = 1'b1;
                    st_wr_addr = current_reg;
                    st_wr_data = SLOT_READY;
                    push_en    = 1'b1;
                    push_id    = current_reg;
                end
                current_next = nxt_reg;
                sw_next      = (nxt_reg != current_reg);
            end
            OP_PRIO_RD:
            begin
                pr_rd_en = 1'b1;
            end
            OP_RESP:
            begin
                done_next   = 1'b1;
                status_next = dp_cmd.status;
                prev_o_next = ID_OUT_W'(prev_reg);
                sw_o_next   = sw_reg;
                reap_o_next = REAP_W'(reap_reg);
                if (dp_cmd.add_resp)
                begin
                    if (dp_cmd.status == ST_DONE)
                    begin
                        id_next     = ID_OUT_W'(scan_reg);
                        prio_o_next = nprio_reg;
                    end
                    else
                    begin
                        id_next     = '0;
                        prio_o_next = '0;
                    end
                end
                else
                begin
                    id_next     = ID_OUT_W'(current_reg);
                    prio_o_next = prio_rd_reg;
                end
            end
            default:
            begin
            end
        endcase

        // a push into a full ring is dropped
        push_ok = push_en && (count_reg != FULL_CNT);
        if (push_ok)
        begin
            tail_next  = id_inc(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end
        if (st_wr_en)
        begin
            state_vld_next[st_wr_addr] = 1'b1;
        end
        if (pr_wr_en)
        begin
            prio_vld_next[pr_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            current_reg   <= '0;
            preempt_reg   <= 1'b0;
            done_reg      <= 1'b0;
            state_vld_reg <= '0;
            prio_vld_reg  <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            current_reg   <= current_next;
            preempt_reg   <= preempt_next;
            done_reg      <= done_next;
            state_vld_reg <= state_vld_next;
            prio_vld_reg  <= prio_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        nxt_reg     <= nxt_next;
        old_run_reg <= old_run_next;
        prev_reg    <= prev_next;
        sw_reg      <= sw_next;
        reap_reg    <= reap_next;
        nprio_reg   <= nprio_next;
        status_reg  <= status_next;
        id_reg      <= id_next;
        prev_o_reg  <= prev_o_next;
        sw_o_reg    <= sw_o_next;
        reap_o_reg  <= reap_o_next;
        prio_o_reg  <= prio_o_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_wr_en)
        begin
            state_mem[st_wr_addr] <= st_wr_data;
        end
        if (st_rd_en)
        begin
            if (state_vld_reg[st_rd_addr])
            begin
                state_rd_reg <= state_mem[st_rd_addr];
            end
            else
            begin
                state_rd_reg <= (st_rd_addr == '0) ? SLOT_RUNNING : SLOT_FREE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pr_wr_en)
        begin
            prio_mem[pr_wr_addr] <= pr_wr_data;
        end
        if (pr_rd_en)
        begin
            if (prio_vld_reg[current_reg])
            begin
                prio_rd_reg <= prio_mem[current_reg];
            end
            else
            begin
                prio_rd_reg <= (current_reg == '0) ? IDLE_PRIO : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            fifo_mem[tail_reg] <= push_id;
        end
        if (fifo_rd_en)
        begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
    end

    assign dp_stat.slot_free   = (state_rd_reg == SLOT_FREE);
    assign dp_stat.slot_term   = (state_rd_reg == SLOT_TERM);
    assign dp_stat.scan_last   = (scan_reg == LAST_ID);
    assign dp_stat.queue_empty = (count_reg == '0);
    assign dp_stat.preempt     = preempt_reg;

    assign done          = done_reg;
    assign status        = status_reg;
    assign task_id       = id_reg;
    assign previous_id   = prev_o_reg;
    assign switched      = sw_o_reg;
    assign reaped_count  = reap_o_reg;
    assign task_priority = prio_o_reg;

endmodule

@@ sv/rrts_ctrl.sv @@
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] command,
    output logic             busy,
    output dp_cmd_t          dp_cmd,
    input  dp_stat_t         dp_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCHED_RD,
        S_SCHED_POP,
        S_SCHED_REQ,
        S_PRIO_RD,
        S_RESP
    } state_t;

    state_t  state_reg,  state_next;
    cmd_t    cmd_reg,    cmd_next;
    status_t status_reg, status_next;
    logic    add_reg,    add_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        add_next    = add_reg;

        dp_cmd             = '0;
        dp_cmd.op          = OP_NONE;
        dp_cmd.status      = status_reg;
        dp_cmd.add_resp    = add_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.cap  = 1'b1;
                    cmd_next    = cmd_t'(command);
                    status_next = ST_DONE;
                    add_next    = 1'b0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        dp_cmd.op  = OP_SCAN_INIT;
                        add_next   = 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    CMD_REAP:
                    begin
                        dp_cmd.op         = OP_SCAN_INIT;
                        dp_cmd.preempt_on = 1'b1;
                        state_next        = S_SCAN_RD;
                    end
                    CMD_SCHEDULE, CMD_EXIT, CMD_TICK:
                    begin
                        if (cmd_reg == CMD_EXIT)
                        begin
                            dp_cmd.op = OP_EXIT_MARK;
                        end
                        if (cmd_reg == CMD_TICK && !dp_stat.preempt)
                        begin
                            status_next = ST_NO_SWITCH;
                            state_next  = S_PRIO_RD;
                        end
                        else
                        begin
                            dp_cmd.preempt_on = 1'b1;
                            if (dp_stat.queue_empty)
                            begin
                                status_next = ST_NO_SWITCH;
                                state_next  = S_PRIO_RD;
                            end
                            else
                            begin
                                state_next = S_SCHED_RD;
                            end
                        end
                    end
                    CMD_PREEMPT_ON:
                    begin
                        dp_cmd.preempt_on = 1'b1;
                        state_next        = S_PRIO_RD;
                    end
                    CMD_PREEMPT_OFF:
                    begin
                        dp_cmd.preempt_off = 1'b1;
                        state_next         = S_PRIO_RD;
                    end
                    default:
                    begin
                        state_next = S_PRIO_RD;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                dp_cmd.op  = OP_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (add_reg)
                begin
                    if (dp_stat.slot_free)
                    begin
                        dp_cmd.op  = OP_ADD_COMMIT;
                        state_next = S_RESP;
                    end
                    else if (dp_stat.scan_last)
                    begin
                        status_next = ST_NO_SLOT;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        dp_cmd.op  = OP_SCAN_NEXT;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (dp_stat.slot_term)
                    begin
                        dp_cmd.op = OP_REAP_FREE;
                    end
                    else if (!dp_stat.scan_last)
                    begin
                        dp_cmd.op = OP_SCAN_NEXT;
                    end
                    state_next = dp_stat.scan_last ? S_PRIO_RD : S_SCAN_RD;
                end
            end
            S_SCHED_RD:
            begin
                dp_cmd.op  = OP_SCHED_RD;
                state_next = S_SCHED_POP;
            end
            S_SCHED_POP:
            begin
                dp_cmd.op  = OP_SCHED_POP;
                state_next = S_SCHED_REQ;
            end
            S_SCHED_REQ:
            begin
                dp_cmd.op  = OP_SCHED_REQ;
                state_next = S_PRIO_RD;
            end
            S_PRIO_RD:
            begin
                dp_cmd.op  = OP_PRIO_RD;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                dp_cmd.op  = OP_RESP;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_READ;
            status_reg <= ST_DONE;
            add_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            add_reg    <= add_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ sv/rrts_checker.sv @@
module rrts_checker
    import rrts_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [ID_OUT_W-1:0] task_id,
    input logic                switched,
    input logic [PRIO_W-1:0]   task_priority
);

    // an accepted beat holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // a result only closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe without a preceding busy period");

    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_NO_SLOT) |-> (task_id == '0) && (task_priority == '0))
        else $error("failed add reported a nonzero id or priority");

    a_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_NO_SWITCH) |-> !switched)
        else $error("switch reported with no-switch status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_DONE) || (status == ST_NO_SLOT) || (status == ST_NO_SWITCH))
        else $error("undefined status code");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .task_id       (task_id),
    .switched      (switched),
    .task_priority (task_priority)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import rrts_pkg::*;

    localparam int NSLOTS         = TASK_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        status_t               status;
        logic [ID_OUT_W-1:0]   task_id;
        logic [ID_OUT_W-1:0]   previous_id;
        logic                  switched;
        logic [REAP_W-1:0]     reaped_count;
        logic [PRIO_W-1:0]     task_priority;
    } sched_outcome_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic [CMD_W-1:0]    command;
    logic [PRIO_W-1:0]   new_priority;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [ID_OUT_W-1:0] task_id;
    logic [ID_OUT_W-1:0] previous_id;
    logic                switched;
    logic [REAP_W-1:0]   reaped_count;
    logic [PRIO_W-1:0]   task_priority;

    // scheduler shadow state
    slot_state_t   slot_st [NSLOTS];
    logic [3:0]    slot_prio [NSLOTS];
    int            ready_ring [NSLOTS];
    int            ring_head;
    int            ring_tail;
    int            ring_count;
    int            running_id;
    bit            preempt_armed;

    sched_outcome_t pending_outcomes [$];
    int             mismatches = 0;
    int             sender_idle_pct = 0;
    int             idle_streak = 0;

    round_robin_task_scheduler_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .new_priority  (new_priority),
        .done          (done),
        .status        (status),
        .task_id       (task_id),
        .previous_id   (previous_id),
        .switched      (switched),
        .reaped_count  (reaped_count),
        .task_priority (task_priority)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void reset_shadow();
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_st[i]    = SLOT_FREE;
            slot_prio[i]  = '0;
            ready_ring[i] = 0;
        end
        slot_st[0]    = SLOT_RUNNING;
        slot_prio[0]  = 4'(PRIORITY_LEVELS_DEF - 1);
        ring_head     = 0;
        ring_tail     = 0;
        ring_count    = 0;
        running_id    = 0;
        preempt_armed = 1'b0;
    endfunction

    function automatic void ring_push(int id);
        if (ring_count < NSLOTS)
        begin
            ready_ring[ring_tail] = id;
            ring_tail = (ring_tail + 1) % NSLOTS;
            ring_count++;
        end
    endfunction

    // pop the queue head into the running slot; the old task is requeued only if
    // it is still running (covers head == current as well)
    function automatic bit dispatch_next(output bit sw);
        int nxt;
        int old;
        bit popped;
        sw = 1'b0;
        popped = 1'b0;
        if (ring_count > 0)
        begin
            nxt = ready_ring[ring_head];
            old = running_id;
            ring_head = (ring_head + 1) % NSLOTS;
            ring_count--;
            slot_st[nxt] = SLOT_RUNNING;
            if (slot_st[old] == SLOT_RUNNING)
            begin
                slot_st[old] = SLOT_READY;
                ring_push(old);
            end
            running_id = nxt;
            sw = (nxt != old);
            popped = 1'b1;
        end
        preempt_armed = 1'b1;
        return popped;
    endfunction

    function automatic sched_outcome_t schedule_outcome(cmd_t cmd, logic [PRIO_W-1:0] prio);
        sched_outcome_t r;
        int prev;
        int found;
        int freed;
        bit sw;
        bit use_running;
        r.status      = ST_DONE;
        r.task_id     = '0;
        r.task_priority = '0;
        prev        = running_id;
        found       = 0;
        freed       = 0;
        sw          = 1'b0;
        use_running = 1'b1;
        case (cmd)
            CMD_ADD:
            begin
                use_running = 1'b0;
                for (int i = NSLOTS - 1; i >= 1; i--)
                    if (slot_st[i] == SLOT_FREE)
                        found = i;
                if (found != 0)
                begin
                    slot_prio[found] = prio;
                    slot_st[found]   = SLOT_READY;
                    ring_push(found);
                    r.task_id       = ID_OUT_W'(found);
                    r.task_priority = prio;
                end
                else
                    r.status = ST_NO_SLOT;
            end
            CMD_SCHEDULE:
                if (!dispatch_next(sw))
                    r.status = ST_NO_SWITCH;
            CMD_EXIT:
            begin
                slot_st[running_id] = SLOT_TERM;
                if (!dispatch_next(sw))
                    r.status = ST_NO_SWITCH;
            end
            CMD_REAP:
            begin
                for (int i = 1; i < NSLOTS; i++)
                    if (slot_st[i] == SLOT_TERM)
                    begin
                        slot_st[i]   = SLOT_FREE;
                        slot_prio[i] = '0;
                        freed++;
                    end
                preempt_armed = 1'b1;
            end
            CMD_TICK:
                if (!preempt_armed || !dispatch_next(sw))
                    r.status = ST_NO_SWITCH;
            CMD_READ: ;
            CMD_PREEMPT_ON:
                preempt_armed = 1'b1;
            default:
                preempt_armed = 1'b0;
        endcase
        if (use_running)
        begin
            r.task_id       = ID_OUT_W'(running_id);
            r.task_priority = slot_prio[running_id];
        end
        r.previous_id  = ID_OUT_W'(prev);
        r.switched     = sw;
        r.reaped_count = REAP_W'(freed);
        return r;
    endfunction

    // one command beat; returns on the edge that takes it
    task automatic send_beat(cmd_t cmd, logic [PRIO_W-1:0] prio);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        command      <= cmd;
        new_priority <= prio;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        pending_outcomes.push_back(schedule_outcome(cmd, prio));
    endtask

    task automatic test_directed_cases();
        send_beat(CMD_READ, 4'($urandom));
        send_beat(CMD_TICK, 4'($urandom));          // preemption off at reset
        send_beat(CMD_PREEMPT_ON, 4'($urandom));
        send_beat(CMD_TICK, 4'($urandom));          // empty queue
        send_beat(CMD_PREEMPT_OFF, 4'($urandom));
        send_beat(CMD_SCHEDULE, 4'($urandom));      // empty, re-arms preemption
        send_beat(CMD_TICK, 4'($urandom));
        send_beat(CMD_ADD, 4'hf);
        send_beat(CMD_EXIT, 4'($urandom));          // idle task exits
        send_beat(CMD_REAP, 4'($urandom));          // slot 0 never freed
        send_beat(CMD_EXIT, 4'($urandom));          // exit with nothing ready
        send_beat(CMD_REAP, 4'($urandom));
        send_beat(CMD_READ, 4'($urandom));
        send_beat(CMD_ADD, 4'h7);                   // reuses the current slot
        send_beat(CMD_SCHEDULE, 4'($urandom));      // head equals current
        send_beat(CMD_ADD, 4'h0);
        send_beat(CMD_ADD, 4'ha);
        send_beat(CMD_PREEMPT_OFF, 4'($urandom));
        send_beat(CMD_TICK, 4'($urandom));
        send_beat(CMD_PREEMPT_ON, 4'($urandom));
        send_beat(CMD_TICK, 4'($urandom));
        send_beat(CMD_READ, 4'($urandom));
    endtask

    task automatic test_slot_exhaustion();
        repeat (70)
            send_beat(CMD_ADD, 4'($urandom));
        repeat (40)
            send_beat($urandom_range(1) ? CMD_EXIT : CMD_TICK, 4'($urandom));
        send_beat(CMD_REAP, 4'($urandom));
    endtask

    task automatic test_random_traffic(int beats, int idle_pct);
        int pick;
        cmd_t cmd;
        sender_idle_pct = idle_pct;
        repeat (beats)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                cmd = CMD_ADD;
            else if (pick < 42)
                cmd = CMD_SCHEDULE;
            else if (pick < 57)
                cmd = CMD_EXIT;
            else if (pick < 63)
                cmd = CMD_REAP;
            else if (pick < 78)
                cmd = CMD_TICK;
            else if (pick < 85)
                cmd = CMD_READ;
            else if (pick < 93)
                cmd = CMD_PREEMPT_ON;
            else
                cmd = CMD_PREEMPT_OFF;
            send_beat(cmd, 4'($urandom));
        end
    endtask

    function automatic void check_field(string name, logic [6:0] exp_v, logic [6:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // results are held for one cycle only; sample mid-cycle
    always @(negedge clk)
    begin
        sched_outcome_t exp_r;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, status %0d task_id %0d",
                         $time, status, task_id);
                mismatches++;
            end
            else
            begin
                exp_r = pending_outcomes.pop_front();
                check_field("status", 7'(exp_r.status), 7'(status));
                check_field("task_id", 7'(exp_r.task_id), 7'(task_id));
                check_field("previous_id", 7'(exp_r.previous_id), 7'(previous_id));
                check_field("switched", 7'(exp_r.switched), 7'(switched));
                check_field("reaped_count", 7'(exp_r.reaped_count), 7'(reaped_count));
                check_field("task_priority", 7'(exp_r.task_priority), 7'(task_priority));
            end
        end
    end

    always @(negedge clk)
    begin
        if (done === 1'b1 || (start === 1'b1 && busy === 1'b0))
            idle_streak = 0;
        else
            idle_streak++;
        if (idle_streak >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        command      <= CMD_READ;
        new_priority <= '0;
        reset_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_slot_exhaustion();
        test_random_traffic(300, 0);
        test_random_traffic(300, 50);
        test_random_traffic(280, 33);
        start <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/rrts_pkg.sv
sv/rrts_datapath.sv
sv/rrts_ctrl.sv
sv/round_robin_task_scheduler_core.sv
sv/rrts_checker.sv
test/tb_top.sv
